// File: design/assert_macros.svh
// Assertion macros for the port-level checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define WTSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while the active-low reset is asserted.
`define WTSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/wtsc_pkg.sv
// Package for the wave-table sound channel: event codes, register indexes,
// payload structs and constants. Depends on nothing.
package wtsc_pkg;

	localparam int WAVE_BYTES = 16;
	localparam int WAVE_AW    = $clog2(WAVE_BYTES);

	typedef enum logic [2:0] {
		FUNC_TICK   = 3'd0,
		FUNC_FRAME  = 3'd1,
		FUNC_REG_RD = 3'd2,
		FUNC_REG_WR = 3'd3,
		FUNC_RAM_RD = 3'd4,
		FUNC_RAM_WR = 3'd5,
		FUNC_SAMPLE = 3'd6,
		FUNC_RESET  = 3'd7
	} func_t;

	localparam logic [3:0] REG_DAC    = 4'd0;
	localparam logic [3:0] REG_LENGTH = 4'd1;
	localparam logic [3:0] REG_VOLUME = 4'd2;
	localparam logic [3:0] REG_PLOW   = 4'd3;
	localparam logic [3:0] REG_PHIGH  = 4'd4;

	localparam logic [7:0] RD_MASK_DAC    = 8'h7F;
	localparam logic [7:0] RD_MASK_VOLUME = 8'h9F;
	localparam logic [7:0] RD_MASK_PHIGH  = 8'hBF;
	localparam logic [7:0] RD_ALL_ONES    = 8'hFF;

	localparam logic [11:0] PERIOD_SPAN = 12'd2048;
	localparam logic [8:0]  LENGTH_FULL = 9'd256;

	typedef enum logic [1:0] {
		SRC_REG    = 2'd0,
		SRC_RAM    = 2'd1,
		SRC_SAMPLE = 2'd2
	} rsrc_t;

	typedef struct packed {
		logic [2:0] func;
		logic [3:0] address;
		logic [7:0] write_data;
		logic [2:0] sequencer_step;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] level;
		logic       status;
		logic       channel_on;
	} res_t;

	function automatic logic [2:0] vol_shift(input logic [1:0] code);
		logic [2:0] s;
		case (code)
			2'd0: s = 3'd4;
			2'd1: s = 3'd0;
			2'd2: s = 3'd1;
			2'd3: s = 3'd2;
			default: s = 3'd4;
		endcase
		return s;
	endfunction

endpackage

// File: design/wtsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wtsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/wave_table_sound_channel_top.sv
// Wave-table sound channel top level: control registers, wave RAM, result stage.
// Depends on wtsc_pkg and wtsc_ram.
//
// channel | valid     | stall     | payload
// --------+-----------+-----------+---------------------
// input   | cmd_valid | cmd_stall | cmd (cmd_t)
// output  | res_valid | res_stall | res (res_t)
//
// One event per cycle while cmd_stall is low; each result passes through the wave
// RAM read stage and then the result register. Control state updates at the
// transaction edge. Reset clears control state and marks every wave RAM
// byte as reading zero. A stalled result holds; input stalls only when both
// the read stage and the result register are full.
module wave_table_sound_channel_top import wtsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic        dac_q, dac_d;
	logic [1:0]  vol_q, vol_d;
	logic [7:0]  plow_q, plow_d;
	logic [7:0]  phigh_q, phigh_d;
	logic [10:0] cd_q, cd_d;
	logic [4:0]  step_q, step_d;
	logic [8:0]  len_q, len_d;
	logic        en_q, en_d;
	logic [WAVE_BYTES-1:0] wvld_q;

	logic        acc;
	logic        adv_s1;
	func_t       fn;
	logic [7:0]  rd_c;
	logic        st_c;
	rsrc_t       src_c;
	logic [10:0] period;
	logic [11:0] diff;
	logic [10:0] reload;
	logic [8:0]  len_dec;

	logic              ram_we;
	logic              ram_re;
	logic [WAVE_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	logic        vld_s1;
	rsrc_t       src_s1;
	logic [7:0]  rd_s1;
	logic        st_s1;
	logic        on_s1;
	logic        en_s1;
	logic        lo_s1;
	logic [2:0]  shift_s1;
	logic        wvld_s1;

	logic [3:0]  nib;
	res_t        res_c;
	res_t        res_q;
	logic        res_valid_q;

	assign fn        = func_t'(cmd.func);
	assign adv_s1    = vld_s1 & (~res_valid_q | ~res_stall);
	assign cmd_stall = vld_s1 & ~adv_s1;
	assign acc       = cmd_valid & ~cmd_stall;

	assign period  = {phigh_q[2:0], plow_q};
	assign diff    = PERIOD_SPAN - {1'b0, period};
	assign len_dec = len_q - 9'd1;

	always_comb begin
		reload = diff[11:1];
		if (reload == '0) begin
			reload = 11'd1;
		end
	end

	always_comb begin
		dac_d   = dac_q;
		vol_d   = vol_q;
		plow_d  = plow_q;
		phigh_d = phigh_q;
		cd_d    = cd_q;
		step_d  = step_q;
		len_d   = len_q;
		en_d    = en_q;
		rd_c    = '0;
		st_c    = 1'b0;
		src_c   = SRC_REG;
		case (fn)
			FUNC_TICK: begin
				if (cd_q == '0) begin
					cd_d   = reload - 11'd1;
					step_d = step_q + 5'd1;
				end else begin
					cd_d = cd_q - 11'd1;
				end
			end
			FUNC_FRAME: begin
				if (!cmd.sequencer_step[0] && phigh_q[6] && len_q != '0) begin
					len_d = len_dec;
					en_d  = (len_dec != '0);
				end
			end
			FUNC_REG_RD: begin
				case (cmd.address)
					REG_DAC:    rd_c = {dac_q, 7'd0} | RD_MASK_DAC;
					REG_LENGTH: rd_c = RD_ALL_ONES;
					REG_VOLUME: rd_c = {1'b0, vol_q, 5'd0} | RD_MASK_VOLUME;
					REG_PLOW:   rd_c = RD_ALL_ONES;
					REG_PHIGH:  rd_c = phigh_q | RD_MASK_PHIGH;
					default:    st_c = 1'b1;
				endcase
			end
			FUNC_REG_WR: begin
				case (cmd.address)
					REG_DAC: begin
						dac_d = cmd.write_data[7];
						en_d  = en_q & cmd.write_data[7];
					end
					REG_LENGTH: len_d = LENGTH_FULL - {1'b0, cmd.write_data};
					REG_VOLUME: vol_d = cmd.write_data[6:5];
					REG_PLOW:   plow_d = cmd.write_data;
					REG_PHIGH: begin
						phigh_d = cmd.write_data;
						if (cmd.write_data[7]) begin
							en_d   = dac_q;
							step_d = '0;
							if (len_q == '0) begin
								len_d = LENGTH_FULL;
							end
						end
					end
					default: st_c = 1'b1;
				endcase
			end
			FUNC_RAM_RD: src_c = SRC_RAM;
			FUNC_RAM_WR: ;
			FUNC_SAMPLE: src_c = SRC_SAMPLE;
			FUNC_RESET: begin
				dac_d   = 1'b0;
				vol_d   = '0;
				plow_d  = '0;
				phigh_d = '0;
				cd_d    = '0;
				step_d  = '0;
				len_d   = '0;
				en_d    = 1'b0;
			end
			default: ;
		endcase
	end

	assign ram_we    = acc & (fn == FUNC_RAM_WR);
	assign ram_re    = acc;
	assign ram_raddr = (fn == FUNC_SAMPLE) ? step_q[4:1] : cmd.address[WAVE_AW-1:0];

	wtsc_ram #(
		.WIDTH(8),
		.DEPTH(WAVE_BYTES)
	) u_sample_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd.address[WAVE_AW-1:0]),
		.wdata(cmd.write_data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_q   <= 1'b0;
			vol_q   <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			cd_q    <= '0;
			step_q  <= '0;
			len_q   <= '0;
			en_q    <= 1'b0;
			wvld_q  <= '0;
		end else if (acc) begin
			dac_q   <= dac_d;
			vol_q   <= vol_d;
			plow_q  <= plow_d;
			phigh_q <= phigh_d;
			cd_q    <= cd_d;
			step_q  <= step_d;
			len_q   <= len_d;
			en_q    <= en_d;
			if (ram_we) begin
				wvld_q[cmd.address[WAVE_AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			src_s1   <= src_c;
			rd_s1    <= rd_c;
			st_s1    <= st_c;
			on_s1    <= en_d;
			en_s1    <= en_q;
			lo_s1    <= step_q[0];
			shift_s1 <= vol_shift(vol_q);
			wvld_s1  <= wvld_q[ram_raddr];
		end
	end

	always_comb begin
		nib = lo_s1 ? ram_rdata[3:0] : ram_rdata[7:4];
		if (!wvld_s1) begin
			nib = '0;
		end
		res_c            = '0;
		res_c.status     = st_s1;
		res_c.channel_on = on_s1;
		case (src_s1)
			SRC_REG:    res_c.read_data = rd_s1;
			SRC_RAM:    res_c.read_data = wvld_s1 ? ram_rdata : 8'd0;
			SRC_SAMPLE: res_c.level = en_s1 ? (nib >> shift_s1) : 4'd0;
			default:    res_c.read_data = rd_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: design/wtsc_checker.sv
// Port-level checker for the wave-table sound channel, bound to the top level.
// Depends on wtsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wtsc_checker import wtsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// hold a stalled transaction
	`WTSC_ASSERT_IMPL(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid, "result dropped while stalled")
	`WTSC_ASSERT_IMPL(a_res_stable, clk, arst_n, res_valid && res_stall, $stable(res), "stalled result changed")
	`WTSC_ASSERT(a_level_on, clk, arst_n, !(res_valid && res.level != 4'd0) || res.channel_on, "level while channel off")
	`WTSC_ASSERT(a_bad_idx, clk, arst_n, !(res_valid && res.status) || (res.read_data == 8'd0 && res.level == 4'd0), "bad index result not zero")

endmodule

bind wave_table_sound_channel_top wtsc_checker u_wtsc_checker (.*);

// File: test/wtsc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wave-table sound channel: mirrors the channel state from
// the accepted events, predicts each result and compares it field by field.
// Depends on wtsc_pkg.
module wtsc_scoreboard import wtsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   audible
);

	localparam logic [3:0][2:0] SHIFT_BY_CODE = {3'd2, 3'd1, 3'd0, 3'd4};

	logic        dac_on;
	logic [1:0]  vol_code;
	logic [7:0]  per_lo;
	logic [7:0]  per_hi_ctl;
	logic [10:0] countdown;
	logic [4:0]  wave_pos;
	logic [8:0]  len_left;
	logic        chan_en;
	logic [7:0]  wave_image [WAVE_BYTES];
	res_t        expected_results [$];

	task clear_channel();
		dac_on     = 1'b0;
		vol_code   = '0;
		per_lo     = '0;
		per_hi_ctl = '0;
		countdown  = '0;
		wave_pos   = '0;
		len_left   = '0;
		chan_en    = 1'b0;
	endtask

	task apply_event(input cmd_t c, output res_t r);
		logic [11:0] reload;
		logic [7:0]  sample_byte;
		logic [3:0]  nibble;
		r = '0;
		case (c.func)
			FUNC_TICK: begin
				if (countdown == '0) begin
					reload = (PERIOD_SPAN - {1'b0, per_hi_ctl[2:0], per_lo}) >> 1;
					if (reload == '0)
						reload = 12'd1;
					countdown = reload[10:0];
					wave_pos  = wave_pos + 5'd1;
				end
				countdown = countdown - 11'd1;
			end
			FUNC_FRAME: begin
				if (!c.sequencer_step[0] && per_hi_ctl[6] && len_left != '0) begin
					len_left = len_left - 9'd1;
					chan_en  = (len_left != '0);
				end
			end
			FUNC_REG_RD: begin
				case (c.address)
					REG_DAC:    r.read_data = {dac_on, 7'd0} | RD_MASK_DAC;
					REG_LENGTH: r.read_data = RD_ALL_ONES;
					REG_VOLUME: r.read_data = {1'b0, vol_code, 5'd0} | RD_MASK_VOLUME;
					REG_PLOW:   r.read_data = RD_ALL_ONES;
					REG_PHIGH:  r.read_data = per_hi_ctl | RD_MASK_PHIGH;
					default:    r.status = 1'b1;
				endcase
			end
			FUNC_REG_WR: begin
				case (c.address)
					REG_DAC: begin
						dac_on  = c.write_data[7];
						chan_en = chan_en & dac_on;
					end
					REG_LENGTH: len_left = LENGTH_FULL - {1'b0, c.write_data};
					REG_VOLUME: vol_code = c.write_data[6:5];
					REG_PLOW:   per_lo = c.write_data;
					REG_PHIGH: begin
						per_hi_ctl = c.write_data;
						if (c.write_data[7]) begin
							chan_en = dac_on;
							if (len_left == '0)
								len_left = LENGTH_FULL;
							wave_pos = '0;
						end
					end
					default: r.status = 1'b1;
				endcase
			end
			FUNC_RAM_RD: r.read_data = wave_image[c.address];
			FUNC_RAM_WR: wave_image[c.address] = c.write_data;
			FUNC_SAMPLE: begin
				if (chan_en) begin
					sample_byte = wave_image[wave_pos[4:1]];
					nibble      = wave_pos[0] ? sample_byte[3:0] : sample_byte[7:4];
					r.level     = nibble >> SHIFT_BY_CODE[vol_code];
				end
			end
			default: clear_channel();
		endcase
		r.channel_on = chan_en;
	endtask

	task compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_channel();
			for (int i = 0; i < WAVE_BYTES; i++)
				wave_image[i] = '0;
			expected_results.delete();
			fail_count = 0;
			checked    = 0;
			audible    = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no event outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("read_data", want.read_data, res.read_data);
					compare_field("level", want.level, res.level);
					compare_field("status", want.status, res.status);
					compare_field("channel_on", want.channel_on, res.channel_on);
					checked++;
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_event(cmd, want);
				if (want.level != '0)
					audible++;
				expected_results.push_back(want);
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top testbench for the wave-table sound channel: clock, reset, event stimulus
// with random idling on both sides, watchdog and verdict.
// Depends on wtsc_pkg, wave_table_sound_channel_top and wtsc_scoreboard.
module tb_top;
	import wtsc_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_POINT  = 200;
	localparam int CALM_START   = 260;
	localparam int CALM_LEN     = 90;
	localparam logic [3:0] BAD_REG_LO = 4'd5;
	localparam logic [3:0] BAD_REG_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int fail_count, pending, checked, audible;
	int sent_total = 0;
	int sent_by_func [8];
	bit calm = 1'b0;
	bit timed_out = 1'b0;
	bit drained_once = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	wave_table_sound_channel_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	wtsc_scoreboard scoreboard_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.audible    (audible)
	);

	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(0, 99) < 16);
	end

	function automatic cmd_t make_event(input func_t f, input logic [3:0] a,
			input logic [7:0] d, input logic [2:0] s);
		cmd_t c;
		c.func           = f;
		c.address        = a;
		c.write_data     = d;
		c.sequencer_step = s;
		return c;
	endfunction

	function automatic cmd_t rand_event(input func_t f);
		return make_event(f, 4'($urandom), 8'($urandom), 3'($urandom));
	endfunction

	task automatic send_event(input cmd_t c);
		if (!calm && $urandom_range(0, 99) < 13) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		sent_by_func[c.func]++;
		sent_total++;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic play_tune();
		int pick;
		logic [7:0] hi;
		repeat ($urandom_range(1, 4))
			send_event(rand_event(FUNC_RAM_WR));
		send_event(make_event(FUNC_REG_WR, REG_DAC,
			($urandom_range(0, 99) < 85) ? (8'($urandom) | 8'h80) : 8'($urandom),
			3'($urandom)));
		send_event(make_event(FUNC_REG_WR, REG_VOLUME, 8'($urandom), 3'($urandom)));
		send_event(make_event(FUNC_REG_WR, REG_PLOW,
			($urandom_range(0, 99) < 60) ? 8'($urandom_range(240, 255)) : 8'($urandom),
			3'($urandom)));
		send_event(make_event(FUNC_REG_WR, REG_LENGTH,
			($urandom_range(0, 99) < 70) ? 8'($urandom_range(248, 255)) : 8'($urandom),
			3'($urandom)));
		hi = 8'($urandom);
		if ($urandom_range(0, 9) != 0)
			hi[7] = 1'b1;
		if ($urandom_range(0, 3) != 0)
			hi[2:0] = 3'b111;
		send_event(make_event(FUNC_REG_WR, REG_PHIGH, hi, 3'($urandom)));
		if ($urandom_range(0, 3) == 0)
			repeat (40)
				send_event(rand_event($urandom_range(0, 1) ? FUNC_TICK : FUNC_SAMPLE));
		repeat ($urandom_range(8, 30)) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				send_event(rand_event(FUNC_TICK));
			else if (pick < 62)
				send_event(rand_event(FUNC_SAMPLE));
			else if (pick < 77)
				send_event(rand_event(FUNC_FRAME));
			else if (pick < 82)
				send_event(rand_event(FUNC_REG_RD));
			else if (pick < 87)
				send_event(rand_event(FUNC_RAM_RD));
			else if (pick < 91)
				send_event(rand_event(FUNC_RAM_WR));
			else if (pick < 94)
				send_event(rand_event(FUNC_REG_WR));
			else if (pick < 96)
				send_event(rand_event(FUNC_RESET));
			else
				send_event(cmd_t'(18'($urandom)));
		end
	endtask

	task automatic watch_progress();
		int idle_run;
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_run = 0;
			else
				idle_run++;
		end
		timed_out = 1'b1;
	endtask

	initial begin
		fork
			begin
				repeat (2) @(posedge clk);
				@(negedge clk);
				arst_n <= 1'b1;
				@(negedge clk);

				send_event(make_event(FUNC_RAM_WR, 4'd0, 8'hFF, 3'd0));
				send_event(make_event(FUNC_RAM_WR, 4'd15, 8'h00, 3'd0));
				send_event(make_event(FUNC_RAM_RD, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_RAM_RD, 4'd15, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_DAC, 8'h80, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_VOLUME, 8'h20, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_PLOW, 8'hFF, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_LENGTH, 8'hFF, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_PHIGH, 8'hC7, 3'd0));
				send_event(make_event(FUNC_SAMPLE, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_TICK, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_SAMPLE, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_RD, REG_DAC, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_RD, REG_LENGTH, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_RD, REG_VOLUME, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_RD, REG_PLOW, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_RD, REG_PHIGH, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_RD, BAD_REG_HI, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_WR, BAD_REG_LO, 8'hFF, 3'd0));
				send_event(make_event(FUNC_FRAME, 4'd0, 8'h00, 3'd1));
				send_event(make_event(FUNC_FRAME, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_SAMPLE, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_VOLUME, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_PHIGH, 8'h87, 3'd0));
				send_event(make_event(FUNC_SAMPLE, 4'd0, 8'h00, 3'd0));
				send_event(make_event(FUNC_REG_WR, REG_DAC, 8'h00, 3'd0));
				send_event(make_event(FUNC_RESET, 4'd0, 8'h00, 3'd0));

				while (sent_total < RANDOM_ITEMS + 27) begin
					if (!drained_once && sent_total >= DRAIN_POINT) begin
						wait_drained();
						drained_once = 1'b1;
					end
					calm = (sent_total >= CALM_START && sent_total < CALM_START + CALM_LEN);
					if ($urandom_range(0, 99) < 80)
						play_tune();
					else
						repeat ($urandom_range(4, 10))
							send_event(cmd_t'(18'($urandom)));
				end
				calm = 1'b0;
				wait_drained();
				repeat (8) @(negedge clk);
			end
			watch_progress();
		join_any

		$display("Sent %0d events: %0d ticks, %0d samples, %0d frame steps, %0d register writes,",
			sent_total, sent_by_func[FUNC_TICK], sent_by_func[FUNC_SAMPLE],
			sent_by_func[FUNC_FRAME], sent_by_func[FUNC_REG_WR]);
		$display("%0d channel resets; %0d results checked, %0d of them audible samples.",
			sent_by_func[FUNC_RESET], checked, audible);
		if (!timed_out && fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
